// ----- rtl/temperature_batch_statistics_core_macros.svh -----
// Assertion macros used by the checker file.
`ifndef TEMPERATURE_BATCH_STATISTICS_CORE_MACROS_SVH
`define TEMPERATURE_BATCH_STATISTICS_CORE_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define TBS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tbs assertion failed");

// Clocked assertion that also holds during reset.
`define TBS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tbs assertion failed during reset");

`endif

// ----- rtl/tbs_pkg.sv -----
// Package: widths, types and helpers of the temperature batch statistics core.
package tbs_pkg;

    localparam int MAX_READINGS = 1024;
    localparam int CNT_W        = $clog2(MAX_READINGS + 1);
    localparam int SUM_W        = 25;
    localparam int READ_W       = 15;
    localparam int IN_W         = 16;
    localparam int OUT_CNT_W    = 11;
    localparam int IDX_W        = 10;
    localparam int IDX_MAX      = 2 ** IDX_W - 1;
    localparam int AVG_MAX      = 2 ** READ_W - 1;
    localparam int STEP_W       = $clog2(SUM_W);
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);
    localparam int OUT_DATA_W   = 128;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    localparam logic [READ_W-1:0] WARN_RESET = READ_W'(480);
    localparam logic [READ_W-1:0] CRIT_RESET = READ_W'(720);
    localparam logic [READ_W-1:0] SHUT_RESET = READ_W'(960);

    typedef enum logic [1:0] {
        REG_WARNING  = 2'd0,
        REG_CRITICAL = 2'd1,
        REG_SHUTDOWN = 2'd2,
        REG_NONE     = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        BAND_NORMAL   = 2'd0,
        BAND_WARNING  = 2'd1,
        BAND_CRITICAL = 2'd2,
        BAND_SHUTDOWN = 2'd3
    } t_band;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_DIV  = 2'd1,
        S_HOLD = 2'd2
    } t_div_state;

    typedef struct packed {
        logic [READ_W-1:0] warning;
        logic [READ_W-1:0] critical;
        logic [READ_W-1:0] shutdown;
    } t_thresh;

    typedef struct packed {
        logic [CNT_W-1:0]  total;
        logic [CNT_W-1:0]  errors;
        logic [CNT_W-1:0]  valid;
        logic [READ_W-1:0] min_val;
        logic [READ_W-1:0] max_val;
        logic [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]  cnt_normal;
        logic [CNT_W-1:0]  cnt_warning;
        logic [CNT_W-1:0]  cnt_critical;
        logic [CNT_W-1:0]  cnt_shutdown;
        logic [IDX_W-1:0]  first_idx;
        logic              seen;
    } t_summary;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < CNT_W'(MAX_READINGS)) ? CNT_W'(v + 1'b1) : CNT_W'(MAX_READINGS);
    endfunction

endpackage

// ----- rtl/temperature_batch_statistics_core.sv -----
// Top level: temperature batch statistics with APB threshold registers.
//
// Input stream: one signed sample (1/16 degree C) per transaction, tlast ends
// a batch. Negative samples count as errors. Samples are taken every cycle
// while o_s_axis_tready is high.
// Output stream: one summary transaction per batch, on the sample with tlast.
// After the last sample, its summary enters the summary queue; the divider
// pops it, forms the average bit-serially, one quotient bit per cycle, and
// then holds the summary with o_m_axis_tvalid high.
// Throughput: one sample per cycle while o_s_axis_tready is high. Summaries
// wait in a two-entry queue for the divider, which takes one at a time; a run
// of short batches fills it and drops o_s_axis_tready until an entry frees.
// When the receiver stalls, the summary holds and the divider waits; the
// front end keeps taking samples until the queue is full.
// Reset: thresholds return to 480, 720 and 960, all statistics clear, the
// queue empties and no summary is pending.
// APB: registers warning, critical, shutdown at 0x0, 0x4, 0x8; pready is high.
module temperature_batch_statistics_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [15:0] reading
    input  logic [tbs_pkg::IN_W-1:0]           i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [10:0] total_count, [21:11] error_count, [36:22] min_reading,
    // [51:37] max_reading, [66:52] average_reading, [77:67] normal_count,
    // [88:78] warning_count, [99:89] critical_count, [110:100] shutdown_count,
    // [120:111] first_critical_index, [121] critical_seen, [122] none_valid
    output logic [tbs_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tbs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tbs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tbs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    tbs_pkg::t_thresh   r_thresh;
    tbs_pkg::t_reg_idx  w_reg;
    logic               w_wr;
    logic               w_full;
    logic               w_empty;
    logic               w_push;
    logic               w_pop;
    tbs_pkg::t_summary  w_front_rec;
    tbs_pkg::t_summary  w_queue_rec;

    assign pready = 1'b1;
    assign w_reg  = tbs_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.warning  <= tbs_pkg::WARN_RESET;
            r_thresh.critical <= tbs_pkg::CRIT_RESET;
            r_thresh.shutdown <= tbs_pkg::SHUT_RESET;
        end else if (w_wr) begin
            unique case (w_reg)
                tbs_pkg::REG_WARNING:  r_thresh.warning  <= pwdata[tbs_pkg::READ_W-1:0];
                tbs_pkg::REG_CRITICAL: r_thresh.critical <= pwdata[tbs_pkg::READ_W-1:0];
                tbs_pkg::REG_SHUTDOWN: r_thresh.shutdown <= pwdata[tbs_pkg::READ_W-1:0];
                default:               r_thresh <= r_thresh;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            tbs_pkg::REG_WARNING:  prdata = tbs_pkg::APB_DATA_W'(r_thresh.warning);
            tbs_pkg::REG_CRITICAL: prdata = tbs_pkg::APB_DATA_W'(r_thresh.critical);
            tbs_pkg::REG_SHUTDOWN: prdata = tbs_pkg::APB_DATA_W'(r_thresh.shutdown);
            default:               prdata = '0;
        endcase
    end

    tbs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_reading (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .i_thresh  (r_thresh),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_rec     (w_front_rec)
    );

    tbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_front_rec),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_rec   (w_queue_rec)
    );

    tbs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_rec   (w_queue_rec),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule

// ----- rtl/tbs_front.sv -----
// Front end: accepts samples, classifies them and accumulates batch statistics.
module tbs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tbs_pkg::IN_W-1:0]      i_reading,
    input  logic                          i_last,
    input  tbs_pkg::t_thresh              i_thresh,
    input  logic                          i_full,
    output logic                          o_push,
    output tbs_pkg::t_summary             o_rec
);

    logic [tbs_pkg::CNT_W-1:0]  r_pos, n_pos;
    logic [tbs_pkg::CNT_W-1:0]  r_err, n_err;
    logic [tbs_pkg::CNT_W-1:0]  r_valid, n_valid;
    logic [tbs_pkg::READ_W-1:0] r_min, n_min;
    logic [tbs_pkg::READ_W-1:0] r_max, n_max;
    logic [tbs_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [tbs_pkg::CNT_W-1:0]  r_band [4];
    logic [tbs_pkg::CNT_W-1:0]  n_band [4];
    logic [tbs_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic                       r_seen, n_seen;

    logic                       w_accept;
    logic                       w_neg;
    logic [tbs_pkg::READ_W-1:0] w_r;
    logic [tbs_pkg::SUM_W:0]    w_sum;
    logic [31:0]                w_pos32;
    tbs_pkg::t_band             w_band;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && i_last;
    assign w_neg    = i_reading[tbs_pkg::IN_W-1];
    assign w_r      = i_reading[tbs_pkg::READ_W-1:0];
    assign w_sum    = {1'b0, r_sum} + (tbs_pkg::SUM_W + 1)'(w_r);
    assign w_pos32  = 32'(r_pos);

    // Bands are tested top down, so unordered thresholds still resolve.
    always_comb begin
        priority if (w_r >= i_thresh.shutdown) begin
            w_band = tbs_pkg::BAND_SHUTDOWN;
        end else if (w_r >= i_thresh.critical) begin
            w_band = tbs_pkg::BAND_CRITICAL;
        end else if (w_r >= i_thresh.warning) begin
            w_band = tbs_pkg::BAND_WARNING;
        end else begin
            w_band = tbs_pkg::BAND_NORMAL;
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_err   = r_err;
        n_valid = r_valid;
        n_min   = r_min;
        n_max   = r_max;
        n_sum   = r_sum;
        n_band  = r_band;
        n_idx   = r_idx;
        n_seen  = r_seen;
        if (w_accept) begin
            n_pos = tbs_pkg::sat_inc(r_pos);
            if (w_neg) begin
                n_err = tbs_pkg::sat_inc(r_err);
            end else begin
                if (r_valid == '0) begin
                    n_min = w_r;
                    n_max = w_r;
                end else begin
                    if (w_r < r_min) n_min = w_r;
                    if (w_r > r_max) n_max = w_r;
                end
                if (r_valid < tbs_pkg::CNT_W'(tbs_pkg::MAX_READINGS)) begin
                    n_sum = w_sum[tbs_pkg::SUM_W] ? '1 : w_sum[tbs_pkg::SUM_W-1:0];
                end
                n_valid = tbs_pkg::sat_inc(r_valid);
                for (int b = 0; b < 4; b++) begin
                    if (w_band == tbs_pkg::t_band'(2'(b))) begin
                        n_band[b] = tbs_pkg::sat_inc(r_band[b]);
                    end
                end
                if (!r_seen && (w_r >= i_thresh.critical)) begin
                    n_seen = 1'b1;
                    n_idx  = (w_pos32 > 32'(tbs_pkg::IDX_MAX)) ?
                             tbs_pkg::IDX_W'(tbs_pkg::IDX_MAX) : tbs_pkg::IDX_W'(w_pos32);
                end
            end
        end
    end

    always_comb begin
        o_rec.total        = n_pos;
        o_rec.errors       = n_err;
        o_rec.valid        = n_valid;
        o_rec.min_val      = n_min;
        o_rec.max_val      = n_max;
        o_rec.sum          = n_sum;
        o_rec.cnt_normal   = n_band[tbs_pkg::BAND_NORMAL];
        o_rec.cnt_warning  = n_band[tbs_pkg::BAND_WARNING];
        o_rec.cnt_critical = n_band[tbs_pkg::BAND_CRITICAL];
        o_rec.cnt_shutdown = n_band[tbs_pkg::BAND_SHUTDOWN];
        o_rec.first_idx    = n_idx;
        o_rec.seen         = n_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_pos   <= '0;
            r_err   <= '0;
            r_valid <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_sum   <= '0;
            for (int b = 0; b < 4; b++) r_band[b] <= '0;
            r_idx   <= '0;
            r_seen  <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_err   <= n_err;
            r_valid <= n_valid;
            r_min   <= n_min;
            r_max   <= n_max;
            r_sum   <= n_sum;
            r_band  <= n_band;
            r_idx   <= n_idx;
            r_seen  <= n_seen;
        end
    end

endmodule

// ----- rtl/tbs_queue.sv -----
// Two-entry queue of batch summaries between front end and divider.
module tbs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tbs_pkg::t_summary i_rec,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output tbs_pkg::t_summary o_rec
);

    tbs_pkg::t_summary             r_mem [tbs_pkg::Q_DEPTH];
    logic [tbs_pkg::Q_PTR_W-1:0]   r_wr_ptr;
    logic [tbs_pkg::Q_PTR_W-1:0]   r_rd_ptr;
    logic [tbs_pkg::Q_CNT_W-1:0]   r_cnt;
    logic                          w_push;
    logic                          w_pop;

    assign o_full  = (r_cnt == tbs_pkg::Q_CNT_W'(tbs_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) r_wr_ptr <= tbs_pkg::Q_PTR_W'(r_wr_ptr + 1'b1);
            if (w_pop)  r_rd_ptr <= tbs_pkg::Q_PTR_W'(r_rd_ptr + 1'b1);
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= tbs_pkg::Q_CNT_W'(r_cnt + 1'b1);
                2'b01:   r_cnt <= tbs_pkg::Q_CNT_W'(r_cnt - 1'b1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/tbs_back.sv -----
// Back end: bit-serial average divider and summary output register.
module tbs_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  tbs_pkg::t_summary                 i_rec,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [tbs_pkg::OUT_DATA_W-1:0]    o_data
);

    tbs_pkg::t_div_state          r_state, n_state;
    tbs_pkg::t_summary            r_rec;
    logic [tbs_pkg::SUM_W-1:0]    r_quo;
    logic [tbs_pkg::CNT_W:0]      r_rem;
    logic [tbs_pkg::STEP_W-1:0]   r_step;

    logic                         w_load;
    logic                         w_run;
    logic                         w_last_step;
    logic [tbs_pkg::CNT_W:0]      w_shift;
    logic [tbs_pkg::CNT_W:0]      w_div;
    logic                         w_ge;
    logic                         w_none;
    logic [tbs_pkg::READ_W-1:0]   w_avg;

    assign w_last_step = (r_step == tbs_pkg::STEP_W'(tbs_pkg::SUM_W - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tbs_pkg::S_IDLE: if (!i_empty) n_state = tbs_pkg::S_DIV;
            tbs_pkg::S_DIV:  if (w_last_step) n_state = tbs_pkg::S_HOLD;
            tbs_pkg::S_HOLD: if (i_ready) n_state = tbs_pkg::S_IDLE;
            default:         n_state = tbs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_load  = (r_state == tbs_pkg::S_IDLE) && !i_empty;
        w_run   = (r_state == tbs_pkg::S_DIV);
        o_valid = (r_state == tbs_pkg::S_HOLD);
        o_pop   = w_load;
    end

    // Restoring division, one quotient bit per cycle, MSB first.
    assign w_shift = {r_rem[tbs_pkg::CNT_W-1:0], r_quo[tbs_pkg::SUM_W-1]};
    assign w_div   = {1'b0, r_rec.valid};
    assign w_ge    = (w_shift >= w_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rec  <= i_rec;
            r_quo  <= i_rec.sum;
            r_rem  <= '0;
            r_step <= '0;
        end else if (w_run) begin
            r_rem  <= w_ge ? (w_shift - w_div) : w_shift;
            r_quo  <= {r_quo[tbs_pkg::SUM_W-2:0], w_ge};
            r_step <= tbs_pkg::STEP_W'(r_step + 1'b1);
        end
    end

    assign w_none = (r_rec.valid == '0);

    always_comb begin
        if (w_none) begin
            w_avg = '0;
        end else if (r_quo > tbs_pkg::SUM_W'(tbs_pkg::AVG_MAX)) begin
            w_avg = tbs_pkg::READ_W'(tbs_pkg::AVG_MAX);
        end else begin
            w_avg = r_quo[tbs_pkg::READ_W-1:0];
        end
    end

    assign o_data = {
        5'b0,
        w_none,
        r_rec.seen,
        r_rec.seen ? r_rec.first_idx : tbs_pkg::IDX_W'(0),
        tbs_pkg::OUT_CNT_W'(r_rec.cnt_shutdown),
        tbs_pkg::OUT_CNT_W'(r_rec.cnt_critical),
        tbs_pkg::OUT_CNT_W'(r_rec.cnt_warning),
        tbs_pkg::OUT_CNT_W'(r_rec.cnt_normal),
        w_avg,
        w_none ? tbs_pkg::READ_W'(0) : r_rec.max_val,
        w_none ? tbs_pkg::READ_W'(0) : r_rec.min_val,
        tbs_pkg::OUT_CNT_W'(r_rec.errors),
        tbs_pkg::OUT_CNT_W'(r_rec.total)
    };

endmodule

// ----- rtl/tbs_checker.sv -----
// Port-level checker for the temperature batch statistics core, with bind.
`include "temperature_batch_statistics_core_macros.svh"

module tbs_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [tbs_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);

    logic        w_stall;
    logic        w_none;
    logic        w_seen;
    logic [44:0] w_stats;
    logic [9:0]  w_idx;

    assign w_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_none  = o_m_axis_tdata[122];
    assign w_seen  = o_m_axis_tdata[121];
    assign w_stats = o_m_axis_tdata[66:22];
    assign w_idx   = o_m_axis_tdata[120:111];

    // Stalled summary stays valid and unchanged.
    `TBS_ASSERT(a_out_hold, i_clk, i_rst_n, w_stall |=> o_m_axis_tvalid)
    `TBS_ASSERT(a_out_stable, i_clk, i_rst_n, w_stall |=> $stable(o_m_axis_tdata))

    // Empty batch reports zero min, max and average.
    `TBS_ASSERT(a_none_zero, i_clk, i_rst_n, (o_m_axis_tvalid && w_none) |-> (w_stats == '0))

    // Without a critical hit the index reads zero.
    `TBS_ASSERT(a_idx_zero, i_clk, i_rst_n, (o_m_axis_tvalid && !w_seen) |-> (w_idx == '0))

    // Reset drops any pending summary.
    `TBS_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind temperature_batch_statistics_core tbs_checker u_tbs_checker (.*);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the temperature batch statistics core.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic [tbs_pkg::IN_W-1:0] reading;
        logic                     last;
    } t_reading_item;

    // Same layout as o_m_axis_tdata, highest field first.
    typedef struct packed {
        logic [4:0]                    pad;
        logic                          none_valid;
        logic                          critical_seen;
        logic [tbs_pkg::IDX_W-1:0]     first_critical_index;
        logic [tbs_pkg::OUT_CNT_W-1:0] shutdown_count;
        logic [tbs_pkg::OUT_CNT_W-1:0] critical_count;
        logic [tbs_pkg::OUT_CNT_W-1:0] warning_count;
        logic [tbs_pkg::OUT_CNT_W-1:0] normal_count;
        logic [tbs_pkg::READ_W-1:0]    average_reading;
        logic [tbs_pkg::READ_W-1:0]    max_reading;
        logic [tbs_pkg::READ_W-1:0]    min_reading;
        logic [tbs_pkg::OUT_CNT_W-1:0] error_count;
        logic [tbs_pkg::OUT_CNT_W-1:0] total_count;
    } t_batch_summary;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    // [15:0] reading
    logic [tbs_pkg::IN_W-1:0]       i_s_axis_tdata = '0;
    logic                           i_s_axis_tlast = 1'b0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    // [10:0] total_count, [21:11] error_count, [36:22] min_reading,
    // [51:37] max_reading, [66:52] average_reading, [77:67] normal_count,
    // [88:78] warning_count, [99:89] critical_count, [110:100] shutdown_count,
    // [120:111] first_critical_index, [121] critical_seen, [122] none_valid
    logic [tbs_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [tbs_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [tbs_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [tbs_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    t_reading_item  pending_readings[$];
    t_batch_summary expected_summaries[$];
    int             fail_count = 0;
    int             tx_idle_pct = 6;
    int             rx_idle_pct = 45;
    logic           hold_req = 1'b0;
    logic           rx_hold = 1'b0;

    // Predictor copy of thresholds and batch statistics.
    logic [tbs_pkg::READ_W-1:0] thr_warning = tbs_pkg::WARN_RESET;
    logic [tbs_pkg::READ_W-1:0] thr_critical = tbs_pkg::CRIT_RESET;
    logic [tbs_pkg::READ_W-1:0] thr_shutdown = tbs_pkg::SHUT_RESET;
    logic [tbs_pkg::CNT_W-1:0]  batch_pos = '0;
    logic [tbs_pkg::CNT_W-1:0]  batch_errors = '0;
    logic [tbs_pkg::CNT_W-1:0]  batch_valid = '0;
    logic [tbs_pkg::READ_W-1:0] batch_min = '0;
    logic [tbs_pkg::READ_W-1:0] batch_max = '0;
    logic [tbs_pkg::SUM_W-1:0]  batch_sum = '0;
    logic [tbs_pkg::CNT_W-1:0]  band_tally[4] = '{default: '0};
    logic [tbs_pkg::IDX_W-1:0]  first_hot_index = '0;
    logic                       hot_found = 1'b0;

    temperature_batch_statistics_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [tbs_pkg::CNT_W-1:0] count_up(
        input logic [tbs_pkg::CNT_W-1:0] v);
        return (v < tbs_pkg::CNT_W'(tbs_pkg::MAX_READINGS)) ?
               tbs_pkg::CNT_W'(v + 1'b1) : tbs_pkg::CNT_W'(tbs_pkg::MAX_READINGS);
    endfunction

    function automatic void clear_batch();
        batch_pos       = '0;
        batch_errors    = '0;
        batch_valid     = '0;
        batch_min       = '0;
        batch_max       = '0;
        batch_sum       = '0;
        band_tally      = '{default: '0};
        first_hot_index = '0;
        hot_found       = 1'b0;
    endfunction

    // Folds one reading into the batch; returns 1 with the summary on tlast.
    function automatic bit fold_reading(input logic [tbs_pkg::IN_W-1:0] raw,
                                        input logic last,
                                        output t_batch_summary summ);
        logic [tbs_pkg::READ_W-1:0] r;
        logic [tbs_pkg::SUM_W:0]    wide;
        logic [tbs_pkg::SUM_W-1:0]  quot;
        summ = '0;
        r = raw[tbs_pkg::READ_W-1:0];
        if (raw[tbs_pkg::IN_W-1]) begin
            batch_errors = count_up(batch_errors);
        end else begin
            if (batch_valid == 0) begin
                batch_min = r;
                batch_max = r;
            end else begin
                if (r < batch_min) batch_min = r;
                if (r > batch_max) batch_max = r;
            end
            // sum freezes once the valid count is full
            if (batch_valid < tbs_pkg::CNT_W'(tbs_pkg::MAX_READINGS)) begin
                wide = {1'b0, batch_sum} + (tbs_pkg::SUM_W + 1)'(r);
                batch_sum = wide[tbs_pkg::SUM_W] ? {tbs_pkg::SUM_W{1'b1}}
                                                 : wide[tbs_pkg::SUM_W-1:0];
            end
            batch_valid = count_up(batch_valid);
            if (r >= thr_shutdown)
                band_tally[tbs_pkg::BAND_SHUTDOWN] =
                    count_up(band_tally[tbs_pkg::BAND_SHUTDOWN]);
            else if (r >= thr_critical)
                band_tally[tbs_pkg::BAND_CRITICAL] =
                    count_up(band_tally[tbs_pkg::BAND_CRITICAL]);
            else if (r >= thr_warning)
                band_tally[tbs_pkg::BAND_WARNING] =
                    count_up(band_tally[tbs_pkg::BAND_WARNING]);
            else
                band_tally[tbs_pkg::BAND_NORMAL] =
                    count_up(band_tally[tbs_pkg::BAND_NORMAL]);
            if (!hot_found && r >= thr_critical) begin
                hot_found = 1'b1;
                first_hot_index = (batch_pos > tbs_pkg::CNT_W'(tbs_pkg::IDX_MAX)) ?
                                  tbs_pkg::IDX_W'(tbs_pkg::IDX_MAX) :
                                  batch_pos[tbs_pkg::IDX_W-1:0];
            end
        end
        batch_pos = count_up(batch_pos);
        if (!last) return 1'b0;

        summ.total_count    = batch_pos;
        summ.error_count    = batch_errors;
        summ.normal_count   = band_tally[tbs_pkg::BAND_NORMAL];
        summ.warning_count  = band_tally[tbs_pkg::BAND_WARNING];
        summ.critical_count = band_tally[tbs_pkg::BAND_CRITICAL];
        summ.shutdown_count = band_tally[tbs_pkg::BAND_SHUTDOWN];
        summ.critical_seen  = hot_found;
        summ.first_critical_index = hot_found ? first_hot_index : '0;
        summ.none_valid     = (batch_valid == 0);
        if (batch_valid != 0) begin
            summ.min_reading = batch_min;
            summ.max_reading = batch_max;
            quot = batch_sum / tbs_pkg::SUM_W'(batch_valid);
            summ.average_reading = (quot > tbs_pkg::AVG_MAX) ?
                                   tbs_pkg::READ_W'(tbs_pkg::AVG_MAX) :
                                   quot[tbs_pkg::READ_W-1:0];
        end
        clear_batch();
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Sender
    always @(posedge i_clk) begin : drv
        t_reading_item nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (pending_readings.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                nxt = pending_readings.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= nxt.reading;
                i_s_axis_tlast  <= nxt.last;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver stall so the summary queue fills and input backs up.
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (500) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Monitor and scoreboard
    always @(posedge i_clk) begin : mon
        t_batch_summary want;
        t_batch_summary got;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (fold_reading(i_s_axis_tdata, i_s_axis_tlast, want))
                    expected_summaries.push_back(want);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_batch_summary'(o_m_axis_tdata);
                if (expected_summaries.size() == 0) begin
                    $display("%0t: unexpected summary, expected none, actual %h",
                             $time, o_m_axis_tdata);
                    fail_count++;
                end else begin
                    want = expected_summaries.pop_front();
                    check_field("total_count", 32'(want.total_count),
                                32'(got.total_count));
                    check_field("error_count", 32'(want.error_count),
                                32'(got.error_count));
                    check_field("min_reading", 32'(want.min_reading),
                                32'(got.min_reading));
                    check_field("max_reading", 32'(want.max_reading),
                                32'(got.max_reading));
                    check_field("average_reading", 32'(want.average_reading),
                                32'(got.average_reading));
                    check_field("normal_count", 32'(want.normal_count),
                                32'(got.normal_count));
                    check_field("warning_count", 32'(want.warning_count),
                                32'(got.warning_count));
                    check_field("critical_count", 32'(want.critical_count),
                                32'(got.critical_count));
                    check_field("shutdown_count", 32'(want.shutdown_count),
                                32'(got.shutdown_count));
                    check_field("first_critical_index", 32'(want.first_critical_index),
                                32'(got.first_critical_index));
                    check_field("critical_seen", 32'(want.critical_seen),
                                32'(got.critical_seen));
                    check_field("none_valid", 32'(want.none_valid),
                                32'(got.none_valid));
                end
            end
        end
    end

    task automatic queue_reading(input int value, input logic last);
        t_reading_item it;
        it.reading = tbs_pkg::IN_W'(value);
        it.last    = last;
        pending_readings.push_back(it);
    endtask

    function automatic logic [tbs_pkg::IN_W-1:0] pick_reading();
        int t;
        case ($urandom_range(9))
            0: return tbs_pkg::IN_W'(32'h8000 | $urandom_range(32767));
            1, 2: begin
                case ($urandom_range(2))
                    0: t = int'(thr_warning);
                    1: t = int'(thr_critical);
                    default: t = int'(thr_shutdown);
                endcase
                t = t + int'($urandom_range(4)) - 2;
                if (t < 0) t = 0;
                if (t > 32767) t = 32767;
                return tbs_pkg::IN_W'(t);
            end
            3: return $urandom_range(1) ? tbs_pkg::IN_W'(0) : tbs_pkg::IN_W'(32767);
            4, 5: return tbs_pkg::IN_W'($urandom_range(32767));
            default: return tbs_pkg::IN_W'($urandom_range(1200));
        endcase
    endfunction

    task automatic queue_batch(input int len);
        for (int i = 0; i < len; i++) queue_reading(pick_reading(), i == len - 1);
    endtask

    task automatic random_batches(input int n_items);
        int total;
        int len;
        total = 0;
        while (total < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            queue_batch(len);
            total += len;
        end
    endtask

    // Returns once every reading is taken and every summary has arrived.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_readings.size() != 0 || i_s_axis_tvalid ||
               expected_summaries.size() != 0);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic apb_write(input tbs_pkg::t_reg_idx idx,
                             input logic [tbs_pkg::APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tbs_pkg::REG_WARNING:  thr_warning  = data[tbs_pkg::READ_W-1:0];
            tbs_pkg::REG_CRITICAL: thr_critical = data[tbs_pkg::READ_W-1:0];
            tbs_pkg::REG_SHUTDOWN: thr_shutdown = data[tbs_pkg::READ_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_thresholds(input logic [tbs_pkg::APB_DATA_W-1:0] warn,
                                  input logic [tbs_pkg::APB_DATA_W-1:0] crit,
                                  input logic [tbs_pkg::APB_DATA_W-1:0] shut);
        apb_write(tbs_pkg::REG_WARNING, warn);
        apb_write(tbs_pkg::REG_CRITICAL, crit);
        apb_write(tbs_pkg::REG_SHUTDOWN, shut);
    endtask

    initial begin
        int w;
        int c;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // band edges and extremes at reset thresholds
        queue_reading(0, 1'b0);
        queue_reading(32767, 1'b0);
        queue_reading(480, 1'b0);
        queue_reading(479, 1'b1);
        queue_reading(719, 1'b0);
        queue_reading(720, 1'b1);
        // errors only: no valid reading
        queue_reading(-1, 1'b0);
        queue_reading(-32768, 1'b1);
        queue_reading(959, 1'b0);
        queue_reading(960, 1'b0);
        queue_reading(5, 1'b1);
        // no critical reading
        queue_reading(100, 1'b1);
        // error shifts the first critical position
        queue_reading(-5, 1'b0);
        queue_reading(1000, 1'b1);
        queue_reading(32767, 1'b0);
        queue_reading(32767, 1'b1);
        wait_idle();

        // write to an unmapped register is dropped
        apb_write(tbs_pkg::REG_NONE, 32'h0000_0010);
        queue_reading(500, 1'b0);
        queue_reading(800, 1'b0);
        queue_reading(1000, 1'b1);
        wait_idle();

        // thresholds out of order: bands still tested from the top
        set_thresholds(1000, 200, 600);
        queue_reading(100, 1'b0);
        queue_reading(300, 1'b0);
        queue_reading(700, 1'b0);
        queue_reading(1200, 1'b1);
        wait_idle();

        w = $urandom_range(2000);
        c = w + $urandom_range(2000);
        set_thresholds(w, c, c + $urandom_range(2000));
        random_batches(25);
        wait_idle();

        hold_req = 1'b1;
        repeat (10) queue_batch($urandom_range(2, 1));
        wait_idle();

        set_thresholds(0, 0, 0);
        random_batches(10);
        wait_idle();

        tx_idle_pct = 45;
        rx_idle_pct = 6;
        set_thresholds(32767, 32767, 32767);
        random_batches(12);
        wait_idle();

        set_thresholds($urandom, $urandom, $urandom);
        random_batches(12);
        wait_idle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        w = $urandom_range(8000);
        c = w + $urandom_range(8000);
        set_thresholds(w, c, c + $urandom_range(8000));
        random_batches(12);
        wait_idle();

        // saturation: total, valid and normal counts pass the limit; the
        // late extremes move min/max and set a clamped first index, not the sum
        set_thresholds(32'(tbs_pkg::WARN_RESET), 32'(tbs_pkg::CRIT_RESET),
                       32'(tbs_pkg::SHUT_RESET));
        repeat (tbs_pkg::MAX_READINGS) queue_reading($urandom_range(479, 1), 1'b0);
        queue_reading(32767, 1'b0);
        queue_reading(0, 1'b1);
        wait_idle();

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tbs_pkg.sv
rtl/tbs_front.sv
rtl/tbs_queue.sv
rtl/tbs_back.sv
rtl/temperature_batch_statistics_core.sv
rtl/tbs_checker.sv
dv/tb_top.sv
